// ===== hw/rtl/palette_blend_nearest_color_assert.svh =====
// Assertion macros for the palette blend block.
// PBNC_ASSERT checks a property; PBNC_NEVER checks that an expression never holds.
`ifndef PALETTE_BLEND_NEAREST_COLOR_ASSERT_SVH
`define PALETTE_BLEND_NEAREST_COLOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PBNC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pbnc: property failed");
`define PBNC_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pbnc: forbidden condition seen");
`else
`define PBNC_ASSERT(lbl, clk, rst, prop)
`define PBNC_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== hw/rtl/pbnc_pkg.sv =====
`timescale 1ns / 1ps
package pbnc_pkg;

   localparam int COMP_W  = 6;
   localparam int MIX_W   = 4;
   localparam int INDEX_W = 8;
   localparam int WGT_W   = 4;
   localparam int ENTRY_W = 3 * COMP_W;
   localparam int DIST_W  = 15;

   localparam logic [WGT_W-1:0]  WEIGHT_FULL = 4'd8;
   localparam int                MIX_SHIFT   = 5;
   localparam logic [1:0]        TARGET_BIAS = 2'b10;
   localparam logic [DIST_W-1:0] INIT_BEST   = 15'd30000;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_BLEND = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [INDEX_W-1:0] entry_index;
      logic [COMP_W-1:0]  entry_red;
      logic [COMP_W-1:0]  entry_green;
      logic [COMP_W-1:0]  entry_blue;
      logic [INDEX_W-1:0] source_index;
      logic [INDEX_W-1:0] destination_index;
      logic [WGT_W-1:0]   blend_weight;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] blended_index;
      logic [MIX_W-1:0]   mixed_red;
      logic [MIX_W-1:0]   mixed_green;
      logic [MIX_W-1:0]   mixed_blue;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic cand_vld;
   } search_ctrl_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_RD_SRC = 6'b000010,
      ST_RD_DST = 6'b000100,
      ST_MIX    = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

endpackage

// ===== hw/rtl/pbnc_ram.sv =====
`timescale 1ns / 1ps
module pbnc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/pbnc_search.sv =====
`timescale 1ns / 1ps
`include "palette_blend_nearest_color_assert.svh"
module pbnc_search #(
   parameter int AW = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pbnc_pkg::search_ctrl_type       ctrl,
   input  logic [AW-1:0]                   cand_idx,
   input  logic [pbnc_pkg::ENTRY_W-1:0]    cand_entry,
   input  logic [pbnc_pkg::MIX_W-1:0]      mix_r,
   input  logic [pbnc_pkg::MIX_W-1:0]      mix_g,
   input  logic [pbnc_pkg::MIX_W-1:0]      mix_b,
   output logic [AW-1:0]                   best_idx
);

   localparam int CW = pbnc_pkg::COMP_W;
   localparam int DW = pbnc_pkg::DIST_W;

   logic [DW-1:0]   best_ff, best_in;
   logic [AW-1:0]   best_idx_ff, best_idx_in;
   logic [2*CW-1:0] sq_r, sq_g, sq_b;
   logic [DW-1:0]   sq_sum;
   logic            closer;

   function automatic logic [2*CW-1:0] sq_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW-1:0] t;
      t = (a > b) ? (a - b) : (b - a);
      return (2*CW)'(t) * (2*CW)'(t);
   endfunction

   assign sq_r = sq_diff({mix_r, pbnc_pkg::TARGET_BIAS}, cand_entry[3*CW-1:2*CW]);
   assign sq_g = sq_diff({mix_g, pbnc_pkg::TARGET_BIAS}, cand_entry[2*CW-1:CW]);
   assign sq_b = sq_diff({mix_b, pbnc_pkg::TARGET_BIAS}, cand_entry[CW-1:0]);
   assign sq_sum = DW'(sq_r) + DW'(sq_g) + DW'(sq_b);
   assign closer = ctrl.cand_vld && (sq_sum < best_ff);

   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (ctrl.clear) begin
         best_in     = pbnc_pkg::INIT_BEST;
         best_idx_in = '0;
      end else if (closer) begin
         best_in     = sq_sum;
         best_idx_in = cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff     <= pbnc_pkg::INIT_BEST;
         best_idx_ff <= '0;
      end else begin
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
      end
   end

   assign best_idx = best_idx_ff;

   `PBNC_ASSERT(a_best_bounded, clock, reset, best_ff <= pbnc_pkg::INIT_BEST)
   `PBNC_ASSERT(a_clear_restarts, clock, reset, ctrl.clear |=> (best_ff == pbnc_pkg::INIT_BEST) && (best_idx_ff == '0))
   `PBNC_ASSERT(a_take_closer, clock, reset, (closer && !ctrl.clear) |=> (best_idx_ff == $past(cand_idx)))

endmodule

// ===== hw/rtl/palette_blend_nearest_color.sv =====
`timescale 1ns / 1ps
// Flow: a blend word is accepted in idle; the block then does two palette reads, one mix
// step, a scan over every palette entry and a drain step before its result is offered.
// Blends go one at a time through the single distance unit and the one read port of the
// palette RAM: no new word is taken until the result is accepted. A palette write gives no result.
// Reset: synchronous; clears control state and every palette valid bit, so all entries read zero.
`include "palette_blend_nearest_color_assert.svh"
module palette_blend_nearest_color #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pbnc_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pbnc_pkg::rsp_type rsp_word
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int IW = pbnc_pkg::INDEX_W;
   localparam int CW = pbnc_pkg::COMP_W;
   localparam int MW = pbnc_pkg::MIX_W;
   localparam int EW = pbnc_pkg::ENTRY_W;
   localparam int WW = pbnc_pkg::WGT_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_ENTRIES - 1);

   pbnc_pkg::state_type state_ff, state_in;

   logic [PALETTE_ENTRIES-1:0] valid_ff, valid_in;
   logic [AW-1:0] src_ff, src_in, dst_ff, dst_in, cnt_ff, cnt_in, cand_idx_ff;
   logic          src_ok_ff, src_ok_in, dst_ok_ff, dst_ok_in;
   logic [WW-1:0] wgt_ff, wgt_in;
   logic [EW-1:0] src_entry_ff, src_entry_in;
   logic [MW-1:0] mix_r_ff, mix_r_in, mix_g_ff, mix_g_in, mix_b_ff, mix_b_in;
   logic          rd_ok_ff, rd_ok_in, cand_vld_ff;

   logic          accept;
   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata, entry;
   logic          rd_in_range;
   logic [AW-1:0] best_idx;
   pbnc_pkg::search_ctrl_type sctrl;

   function automatic logic in_range(input logic [IW-1:0] idx);
      return {1'b0, idx} < (IW+1)'(PALETTE_ENTRIES);
   endfunction

   function automatic logic [MW-1:0] mix_comp(input logic [WW-1:0] w,
                                              input logic [CW-1:0] s,
                                              input logic [CW-1:0] d);
      logic [WW+CW-1:0] ps, pd;
      ps = (WW+CW)'(w) * (WW+CW)'(s);
      pd = (WW+CW)'(pbnc_pkg::WEIGHT_FULL - w) * (WW+CW)'(d);
      return MW'((ps >> pbnc_pkg::MIX_SHIFT) + (pd >> pbnc_pkg::MIX_SHIFT));
   endfunction

   assign req_ready = (state_ff == pbnc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign ram_we    = accept && (req_word.mode == pbnc_pkg::MODE_WRITE)
                      && in_range(req_word.entry_index);
   assign entry     = rd_ok_ff ? ram_rdata : '0;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      src_ok_in    = src_ok_ff;
      dst_ok_in    = dst_ok_ff;
      wgt_in       = wgt_ff;
      cnt_in       = cnt_ff;
      src_entry_in = src_entry_ff;
      mix_r_in     = mix_r_ff;
      mix_g_in     = mix_g_ff;
      mix_b_in     = mix_b_ff;
      ram_raddr    = cnt_ff;
      rd_in_range  = 1'b1;
      sctrl.clear  = 1'b0;
      sctrl.cand_vld = cand_vld_ff;
      case (state_ff)
         pbnc_pkg::ST_IDLE: begin
            if (ram_we) begin
               valid_in[req_word.entry_index[AW-1:0]] = 1'b1;
            end
            if (accept && (req_word.mode == pbnc_pkg::MODE_BLEND)) begin
               src_in    = req_word.source_index[AW-1:0];
               dst_in    = req_word.destination_index[AW-1:0];
               src_ok_in = in_range(req_word.source_index);
               dst_ok_in = in_range(req_word.destination_index);
               wgt_in    = (req_word.blend_weight > pbnc_pkg::WEIGHT_FULL)
                           ? pbnc_pkg::WEIGHT_FULL : req_word.blend_weight;
               state_in  = pbnc_pkg::ST_RD_SRC;
            end
         end
         pbnc_pkg::ST_RD_SRC: begin
            ram_raddr   = src_ff;
            rd_in_range = src_ok_ff;
            state_in    = pbnc_pkg::ST_RD_DST;
         end
         pbnc_pkg::ST_RD_DST: begin
            ram_raddr    = dst_ff;
            rd_in_range  = dst_ok_ff;
            src_entry_in = entry;
            state_in     = pbnc_pkg::ST_MIX;
         end
         pbnc_pkg::ST_MIX: begin
            mix_r_in    = mix_comp(wgt_ff, src_entry_ff[3*CW-1:2*CW], entry[3*CW-1:2*CW]);
            mix_g_in    = mix_comp(wgt_ff, src_entry_ff[2*CW-1:CW], entry[2*CW-1:CW]);
            mix_b_in    = mix_comp(wgt_ff, src_entry_ff[CW-1:0], entry[CW-1:0]);
            sctrl.clear = 1'b1;
            cnt_in      = '0;
            state_in    = pbnc_pkg::ST_SCAN;
         end
         pbnc_pkg::ST_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = pbnc_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         pbnc_pkg::ST_DONE: begin
            if (rsp_valid && rsp_ready) begin
               state_in = pbnc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbnc_pkg::ST_IDLE;
         end
      endcase
      rd_ok_in = rd_in_range && valid_ff[ram_raddr];
   end

   // the last candidate is still compared in the first done cycle; results are read after it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pbnc_pkg::ST_IDLE;
         valid_ff    <= '0;
         cand_vld_ff <= 1'b0;
         rd_ok_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         cand_vld_ff <= (state_ff == pbnc_pkg::ST_SCAN);
         rd_ok_ff    <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      src_ok_ff    <= src_ok_in;
      dst_ok_ff    <= dst_ok_in;
      wgt_ff       <= wgt_in;
      cnt_ff       <= cnt_in;
      cand_idx_ff  <= cnt_ff;
      src_entry_ff <= src_entry_in;
      mix_r_ff     <= mix_r_in;
      mix_g_ff     <= mix_g_in;
      mix_b_ff     <= mix_b_in;
   end

   pbnc_ram #(
      .WIDTH (EW),
      .DEPTH (PALETTE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_word.entry_index[AW-1:0]),
      .wdata ({req_word.entry_red, req_word.entry_green, req_word.entry_blue}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pbnc_search #(
      .AW (AW)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (sctrl),
      .cand_idx   (cand_idx_ff),
      .cand_entry (entry),
      .mix_r      (mix_r_ff),
      .mix_g      (mix_g_ff),
      .mix_b      (mix_b_ff),
      .best_idx   (best_idx)
   );

   // first done cycle still folds in the last candidate, so hold valid off for it
   assign rsp_valid = (state_ff == pbnc_pkg::ST_DONE) && !cand_vld_ff;
   assign rsp_word.blended_index = IW'(best_idx);
   assign rsp_word.mixed_red     = mix_r_ff;
   assign rsp_word.mixed_green   = mix_g_ff;
   assign rsp_word.mixed_blue    = mix_b_ff;

   `PBNC_NEVER(a_ready_xor_result, clock, reset, req_ready && rsp_valid)
   `PBNC_ASSERT(a_blend_blocks, clock, reset, (accept && (req_word.mode == pbnc_pkg::MODE_BLEND)) |=> !req_ready)
   `PBNC_ASSERT(a_result_after_scan, clock, reset, $rose(rsp_valid) |-> $past(cand_vld_ff))

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   localparam int PALETTE_ENTRIES = 256;
   localparam int HOLD_CYCLES     = 1500;
   localparam int WATCHDOG_LIMIT  = 6000;
   localparam int MAX_REPORTS     = 10;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pbnc_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pbnc_pkg::rsp_type rsp_word;

   logic [pbnc_pkg::ENTRY_W-1:0] palette_copy [PALETTE_ENTRIES];
   pbnc_pkg::rsp_type            pending_blends [$];

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_reqs     = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   int mismatch_count = 0;
   int writes_sent   = 0;
   int blends_sent   = 0;
   int results_seen  = 0;

   palette_blend_nearest_color #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic logic [pbnc_pkg::MIX_W-1:0] mix_component(
         input int unsigned wt,
         input logic [pbnc_pkg::COMP_W-1:0] s,
         input logic [pbnc_pkg::COMP_W-1:0] d);
      int unsigned sum;
      sum = (wt * s) / 32 + ((8 - wt) * d) / 32;
      return sum[pbnc_pkg::MIX_W-1:0];
   endfunction

   function automatic logic [pbnc_pkg::ENTRY_W-1:0] read_copy(input int idx);
      return (idx < PALETTE_ENTRIES) ? palette_copy[idx] : '0;
   endfunction

   function automatic pbnc_pkg::rsp_type blend_and_search(input pbnc_pkg::req_type w);
      int unsigned                  wt;
      int                           best;
      int                           sq_sum;
      int                           dr;
      int                           dg;
      int                           db;
      logic [pbnc_pkg::ENTRY_W-1:0] s;
      logic [pbnc_pkg::ENTRY_W-1:0] d;
      logic [pbnc_pkg::ENTRY_W-1:0] e;
      pbnc_pkg::rsp_type            r;
      wt = (w.blend_weight > pbnc_pkg::WEIGHT_FULL) ? 8 : w.blend_weight;
      s  = read_copy(int'(w.source_index));
      d  = read_copy(int'(w.destination_index));
      r.mixed_red   = mix_component(wt, s[17:12], d[17:12]);
      r.mixed_green = mix_component(wt, s[11:6], d[11:6]);
      r.mixed_blue  = mix_component(wt, s[5:0], d[5:0]);
      r.blended_index = '0;
      best = 30000;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         e  = palette_copy[i];
         dr = int'(r.mixed_red) * 4 + 2 - int'(e[17:12]);
         dg = int'(r.mixed_green) * 4 + 2 - int'(e[11:6]);
         db = int'(r.mixed_blue) * 4 + 2 - int'(e[5:0]);
         sq_sum = dr * dr + dg * dg + db * db;
         if (sq_sum < best) begin
            best = sq_sum;
            r.blended_index = i[pbnc_pkg::INDEX_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic pbnc_pkg::req_type write_word(input int idx, input int r, input int g,
                                                    input int b);
      pbnc_pkg::req_type w;
      w             = '0;
      w.mode        = pbnc_pkg::MODE_WRITE;
      w.entry_index = idx[pbnc_pkg::INDEX_W-1:0];
      w.entry_red   = r[pbnc_pkg::COMP_W-1:0];
      w.entry_green = g[pbnc_pkg::COMP_W-1:0];
      w.entry_blue  = b[pbnc_pkg::COMP_W-1:0];
      return w;
   endfunction

   function automatic pbnc_pkg::req_type blend_word(input int src, input int dst, input int wt);
      pbnc_pkg::req_type w;
      w                   = '0;
      w.mode              = pbnc_pkg::MODE_BLEND;
      w.source_index      = src[pbnc_pkg::INDEX_W-1:0];
      w.destination_index = dst[pbnc_pkg::INDEX_W-1:0];
      w.blend_weight      = wt[pbnc_pkg::WGT_W-1:0];
      return w;
   endfunction

   task automatic send_word(input pbnc_pkg::req_type w);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      if (w.mode == pbnc_pkg::MODE_WRITE) begin
         if (int'(w.entry_index) < PALETTE_ENTRIES)
            palette_copy[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue};
         writes_sent++;
      end else begin
         pending_blends.insert(pending_blends.size(), blend_and_search(w));
         blends_sent++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_blends.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_palette();
      send_word(blend_word(0, 255, 15));
      send_word(blend_word(17, 200, 0));
      drain();
   endtask

   task automatic test_component_extremes();
      send_word(write_word(0, 63, 63, 63));
      send_word(write_word(255, 63, 0, 63));
      send_word(write_word(128, 0, 63, 0));
      send_word(write_word(1, 0, 0, 0));
      send_word(blend_word(0, 255, 8));
      send_word(blend_word(0, 255, 0));
      send_word(blend_word(0, 128, 4));
      send_word(blend_word(255, 255, 5));
      send_word(blend_word(128, 0, 1));
      drain();
   endtask

   task automatic test_weight_saturation();
      send_word(blend_word(0, 128, 9));
      send_word(blend_word(255, 128, 15));
      send_word(blend_word(128, 255, 12));
      drain();
   endtask

   task automatic test_nearest_tie();
      // same colour twice: the lower index has to win
      send_word(write_word(20, 12, 34, 56));
      send_word(write_word(10, 12, 34, 56));
      send_word(write_word(30, 40, 8, 20));
      send_word(blend_word(20, 20, 8));
      send_word(blend_word(10, 30, 4));
      send_word(blend_word(30, 30, 15));
      drain();
   endtask

   task automatic test_backpressure_fill();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_reqs++;
      for (int i = 0; i < 6; i++)
         send_word(blend_word($urandom_range(255), $urandom_range(255), $urandom_range(15)));
      drain();
   endtask

   task automatic test_random_traffic(input int count);
      pbnc_pkg::req_type w;
      logic [63:0]       raw;
      for (int i = 0; i < count; i++) begin
         raw = {$urandom, $urandom};
         w   = raw[$bits(pbnc_pkg::req_type)-1:0];
         if ($urandom_range(99) < 45) begin
            w.mode = pbnc_pkg::MODE_WRITE;
            if ($urandom_range(7) == 0)
               {w.entry_red, w.entry_green, w.entry_blue} = palette_copy[$urandom_range(255)];
         end else begin
            w.mode = pbnc_pkg::MODE_BLEND;
         end
         send_word(w);
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_reqs != hold_seen) begin
         hold_seen <= hold_reqs;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      pbnc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_blends.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result word %p", $realtime, rsp_word);
         end else begin
            want = pending_blends.pop_front();
            if (rsp_word.blended_index !== want.blended_index ||
                rsp_word.mixed_red !== want.mixed_red ||
                rsp_word.mixed_green !== want.mixed_green ||
                rsp_word.mixed_blue !== want.mixed_blue) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%0t: mismatch idx exp %0d got %0d,",
                            " rgb exp %0d/%0d/%0d got %0d/%0d/%0d"},
                           $realtime, want.blended_index, rsp_word.blended_index,
                           want.mixed_red, want.mixed_green, want.mixed_blue,
                           rsp_word.mixed_red, rsp_word.mixed_green, rsp_word.mixed_blue);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < PALETTE_ENTRIES; i++)
         palette_copy[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_palette();
      test_component_extremes();
      test_weight_saturation();
      test_nearest_tie();
      test_backpressure_fill();

      req_idle_pct = 0;  rsp_stall_pct = 0;
      test_random_traffic(170);
      req_idle_pct = 54; rsp_stall_pct = 0;
      test_random_traffic(170);
      req_idle_pct = 0;  rsp_stall_pct = 54;
      test_random_traffic(170);
      req_idle_pct = 31; rsp_stall_pct = 31;
      test_random_traffic(170);

      repeat (PALETTE_ENTRIES + 20) @(posedge clock);
      if (pending_blends.size() != 0) begin
         mismatch_count++;
         $display("%0d expected result words never arrived", pending_blends.size());
      end

      $display("Run covered %0d palette writes and %0d blends (%0d results checked),",
               writes_sent, blends_sent, results_seen);
      $display("with idle and stall mixes on both sides and one long result hold-off.");
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
